[rtl/core/sliding_window_duplicate_detector_assert.svh]
// assertion macros for the sliding window duplicate detector checker
`ifndef SLIDING_WINDOW_DUPLICATE_DETECTOR_ASSERT_SVH
`define SLIDING_WINDOW_DUPLICATE_DETECTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SWDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SWDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/swdd_pkg.sv]
// shared constants and types for the sliding window duplicate detector
`timescale 1ns / 1ps
`default_nettype none
package swdd_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int WINDOW_MAX_DEF = 4096;
  localparam int COUNT_BITS_DEF = 20;

  // fixed port widths
  localparam int EXAM_BITS      = 16;
  localparam int WLEN_BITS      = 13;
  localparam int OUT_TOTAL_BITS = 20;

  // set tag kept in every table entry
  localparam int EPOCH_BITS     = 8;

  typedef struct packed {
    logic seen_before;
    logic seen_in_window;
    logic set_done;
  } swdd_flags_t;

endpackage
`default_nettype wire

[rtl/core/swdd_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module swdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[rtl/core/swdd_ctrl.sv]
// sequencer, window register, totals and table update unit
`timescale 1ns / 1ps
`default_nettype none
module swdd_ctrl
  import swdd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int KW = $clog2(WINDOW_MAX + 1),
  localparam int PW = $clog2(WINDOW_MAX),
  localparam int TW = EPOCH_BITS + 1 + KW
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [EXAM_BITS-1:0]  exam_value,
  input  wire logic                  first_of_set,
  input  wire logic                  last_of_set,
  input  wire logic                  cfg_we,
  input  wire logic [WLEN_BITS-1:0]  cfg_wdata,
  output logic                       tbl_we,
  output logic [VALUE_BITS-1:0]      tbl_addr,
  output logic [TW-1:0]              tbl_wdata,
  input  wire logic [TW-1:0]         tbl_rdata,
  output logic                       ring_we,
  output logic [PW-1:0]              ring_addr,
  output logic [VALUE_BITS-1:0]      ring_wdata,
  input  wire logic [VALUE_BITS-1:0] ring_rdata,
  output logic                       done,
  output swdd_flags_t                flags,
  output logic [COUNT_BITS-1:0]      repeat_cnt,
  output logic [COUNT_BITS-1:0]      caught_cnt
);

  localparam int CW = (KW > WLEN_BITS) ? KW : WLEN_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_V,
    S_RD_OLD,
    S_WR_OLD,
    S_WR_V
  } state_t;

  state_t                  state;
  logic [VALUE_BITS-1:0]   clr_addr;
  logic                    item_pend;
  logic [EPOCH_BITS-1:0]   epoch;
  logic [PW-1:0]           pos;
  logic [KW-1:0]           fill;
  logic [WLEN_BITS-1:0]    window_len;
  logic [VALUE_BITS-1:0]   val;
  logic                    last;
  logic [KW-1:0]           k;
  logic                    evict;
  logic                    prior_seen;
  logic                    inwin;
  logic [KW-1:0]           v_cnt;
  logic [VALUE_BITS-1:0]   old_val;
  logic                    old_same;

  logic [31:0]             exam_ext;
  logic [VALUE_BITS-1:0]   v_in;
  logic [CW-1:0]           wl_ext;
  logic [KW-1:0]           k_c;
  logic [KW:0]             pos_ext;
  logic [KW:0]             k_ext;
  logic [KW:0]             idx_ext;
  logic [PW-1:0]           old_idx;
  logic [PW-1:0]           pos_next;
  logic                    ent_hit;
  logic                    eff_seen;
  logic [KW-1:0]           eff_cnt;
  logic [KW-1:0]           eff_cnt_dec;
  logic [KW-1:0]           v_cnt_inc;

  assign busy = (state != S_IDLE);

  assign exam_ext = {{(32 - EXAM_BITS){1'b0}}, exam_value};
  assign v_in     = exam_ext[VALUE_BITS-1:0];

  // effective window length
  assign wl_ext = CW'(window_len);
  always_comb begin
    priority if (window_len == '0) begin
      k_c = KW'(1);
    end else if (wl_ext > CW'(WINDOW_MAX)) begin
      k_c = KW'(WINDOW_MAX);
    end else begin
      k_c = wl_ext[KW-1:0];
    end
  end

  // ring slot of the value leaving the window
  assign pos_ext = (KW+1)'(pos);
  assign k_ext   = {1'b0, k};
  always_comb begin
    if (pos_ext >= k_ext) begin
      idx_ext = pos_ext - k_ext;
    end else begin
      idx_ext = pos_ext + (KW+1)'(WINDOW_MAX) - k_ext;
    end
  end
  assign old_idx  = idx_ext[PW-1:0];
  assign pos_next = (pos == PW'(WINDOW_MAX - 1)) ? '0 : pos + PW'(1);

  // table entry decode, stale set tag reads as zero
  assign ent_hit     = (tbl_rdata[TW-1 -: EPOCH_BITS] == epoch);
  assign eff_seen    = ent_hit & tbl_rdata[KW];
  assign eff_cnt     = ent_hit ? tbl_rdata[KW-1:0] : '0;
  assign eff_cnt_dec = (eff_cnt != '0) ? eff_cnt - KW'(1) : eff_cnt;
  assign v_cnt_inc   = (v_cnt >= KW'(WINDOW_MAX)) ? v_cnt : v_cnt + KW'(1);

  always_comb begin
    tbl_we     = 1'b0;
    tbl_addr   = val;
    tbl_wdata  = '0;
    ring_we    = 1'b0;
    ring_addr  = old_idx;
    ring_wdata = val;
    unique case (state)
      S_CLEAR: begin
        tbl_we   = 1'b1;
        tbl_addr = clr_addr;
      end
      S_IDLE: begin
        tbl_addr = val;
      end
      S_RD_V: begin
        tbl_addr  = val;
        ring_addr = old_idx;
      end
      S_RD_OLD: begin
        tbl_addr = evict ? ring_rdata : val;
      end
      S_WR_OLD: begin
        tbl_we    = evict & ~old_same;
        tbl_addr  = old_val;
        tbl_wdata = {epoch, eff_seen, eff_cnt_dec};
      end
      S_WR_V: begin
        tbl_we    = 1'b1;
        tbl_addr  = val;
        tbl_wdata = {epoch, 1'b1, v_cnt_inc};
        ring_we   = 1'b1;
        ring_addr = pos;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      item_pend  <= 1'b0;
      epoch      <= '0;
      pos        <= '0;
      fill       <= '0;
      repeat_cnt <= '0;
      caught_cnt <= '0;
      window_len <= WLEN_BITS'(1);
      done       <= 1'b0;
      flags      <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        window_len <= cfg_wdata;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + VALUE_BITS'(1);
          if (clr_addr == '1) begin
            state     <= item_pend ? S_RD_V : S_IDLE;
            item_pend <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            val  <= v_in;
            last <= last_of_set;
            k    <= k_c;
            if (first_of_set) begin
              pos        <= '0;
              fill       <= '0;
              repeat_cnt <= '0;
              caught_cnt <= '0;
              if (epoch == '1) begin
                epoch     <= '0;
                clr_addr  <= '0;
                item_pend <= 1'b1;
                state     <= S_CLEAR;
              end else begin
                epoch <= epoch + EPOCH_BITS'(1);
                state <= S_RD_V;
              end
            end else begin
              state <= S_RD_V;
            end
          end
        end
        S_RD_V: begin
          evict <= (fill >= k);
          state <= S_RD_OLD;
        end
        S_RD_OLD: begin
          prior_seen <= eff_seen;
          inwin      <= (eff_cnt != '0);
          v_cnt      <= eff_cnt;
          old_val    <= ring_rdata;
          old_same   <= (ring_rdata == val);
          if (eff_seen && repeat_cnt != '1) begin
            repeat_cnt <= repeat_cnt + COUNT_BITS'(1);
          end
          if (eff_cnt != '0 && caught_cnt != '1) begin
            caught_cnt <= caught_cnt + COUNT_BITS'(1);
          end
          state <= S_WR_OLD;
        end
        S_WR_OLD: begin
          // leaving value equals the new one
          if (evict && old_same && v_cnt != '0) begin
            v_cnt <= v_cnt - KW'(1);
          end
          state <= S_WR_V;
        end
        S_WR_V: begin
          pos <= pos_next;
          if (!evict) begin
            fill <= fill + KW'(1);
          end
          done                 <= 1'b1;
          flags.seen_before    <= prior_seen;
          flags.seen_in_window <= inwin;
          flags.set_done       <= last;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/sliding_window_duplicate_detector.sv]
// top level of the sliding window duplicate detector
`timescale 1ns / 1ps
`default_nettype none
// Takes one request when start is high and busy is low; done rises when the request leaves
// its last write step and is high for exactly one cycle with the flags and totals, and the
// receiver cannot stall it. An item goes through accept, two reads and two writes because
// the value table and the ring each have a single port that every step shares; busy is low
// again in the cycle that done is high. The value table carries a set tag per entry instead
// of being wiped per set; after reset, and on every 2^EPOCH_BITS-th request with first_of_set,
// a sweep over all 2^VALUE_BITS entries clears the table while busy stays high. cfg_we writes
// window_length at once and is meant for idle periods only.
module sliding_window_duplicate_detector
  import swdd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [EXAM_BITS-1:0]      exam_value,
  input  wire logic                      first_of_set,
  input  wire logic                      last_of_set,
  input  wire logic                      cfg_we,
  input  wire logic [WLEN_BITS-1:0]      cfg_wdata,
  output logic                           done,
  output logic                           seen_before,
  output logic                           seen_in_window,
  output logic [OUT_TOTAL_BITS-1:0]      repeat_total,
  output logic [OUT_TOTAL_BITS-1:0]      caught_total,
  output logic                           set_done
);

  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int PW = $clog2(WINDOW_MAX);
  localparam int TW = EPOCH_BITS + 1 + KW;

  logic                  tbl_we;
  logic [VALUE_BITS-1:0] tbl_addr;
  logic [TW-1:0]         tbl_wdata;
  logic [TW-1:0]         tbl_rdata;
  logic                  ring_we;
  logic [PW-1:0]         ring_addr;
  logic [VALUE_BITS-1:0] ring_wdata;
  logic [VALUE_BITS-1:0] ring_rdata;
  swdd_flags_t           flags;
  logic [COUNT_BITS-1:0] repeat_cnt;
  logic [COUNT_BITS-1:0] caught_cnt;
  logic [63:0]           repeat_ext;
  logic [63:0]           caught_ext;

  swdd_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .WINDOW_MAX (WINDOW_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .exam_value   (exam_value),
    .first_of_set (first_of_set),
    .last_of_set  (last_of_set),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .tbl_we       (tbl_we),
    .tbl_addr     (tbl_addr),
    .tbl_wdata    (tbl_wdata),
    .tbl_rdata    (tbl_rdata),
    .ring_we      (ring_we),
    .ring_addr    (ring_addr),
    .ring_wdata   (ring_wdata),
    .ring_rdata   (ring_rdata),
    .done         (done),
    .flags        (flags),
    .repeat_cnt   (repeat_cnt),
    .caught_cnt   (caught_cnt)
  );

  // set tag, seen bit and window count per value
  swdd_ram #(
    .WIDTH (TW),
    .DEPTH (2 ** VALUE_BITS)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

  // ring of recent values
  swdd_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .addr  (ring_addr),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  assign repeat_ext     = 64'(repeat_cnt);
  assign caught_ext     = 64'(caught_cnt);
  assign repeat_total   = repeat_ext[OUT_TOTAL_BITS-1:0];
  assign caught_total   = caught_ext[OUT_TOTAL_BITS-1:0];
  assign seen_before    = flags.seen_before;
  assign seen_in_window = flags.seen_in_window;
  assign set_done       = flags.set_done;

endmodule
`default_nettype wire

[rtl/core/swdd_checker.sv]
// port-level checker for the sliding window duplicate detector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_duplicate_detector_assert.svh"
module swdd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic seen_before,
  input wire logic seen_in_window
);

  `SWDD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after an accepted request")
  `SWDD_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `SWDD_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `SWDD_ASSERT_NOW(a_window_in_set, done && seen_in_window, seen_before,
                   "window match without an earlier match in the set")

endmodule

bind sliding_window_duplicate_detector swdd_checker u_swdd_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .seen_before    (seen_before),
  .seen_in_window (seen_in_window)
);
`default_nettype wire
